FILE: src/mf3_pkg.sv
// Shared constants and types of the 3x3 median filter.
// No dependencies; imported by the top level and the sorting network.
package mf3_pkg;

    localparam int FW_BITS    = 6;
    localparam int FH_BITS    = 11;
    localparam int RC_BITS    = 10;
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;
    localparam int IDX_BITS   = 1;

    localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam int FRAME_WIDTH_RST  = 16;
    localparam int FRAME_HEIGHT_RST = 16;
    localparam int MIN_DIM          = 2;
    localparam int MAX_HEIGHT       = 1024;

    localparam int N_TAPS      = 9;
    localparam int MEDIAN_RANK = 4;

    typedef struct packed {
        logic emit;
        logic top_ok;
        logic mid_ok;
        logic zero_left;
        logic zero_right;
        logic wr_upper;
        logic last;
    } t_ctl;

endpackage

FILE: src/median_filter_3x3_top.sv
// Top level of the 3x3 median filter: row stores, window, flush sequencer, APB registers.
// Depends on mf3_pkg and mf3_median.
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+------------------------------
//  pixel     | in        | i_pixel_valid / o_pixel_ready  | i_pixel_value
//  median    | out       | o_median_valid / i_median_ready| o_median_value, o_frame_end
//  config    | in (APB)  | psel, penable, pwrite / pready | paddr, pwdata, prdata
//
// One pixel per cycle unless stalled or flushing; the pixel that releases a result passes
// through the input register and then the result register.
// On the last pixel of a frame the flush sequencer reads the row stores one column per
// cycle unless stalled, and pixel ready stays low while the last results drain.
// A stalled result holds the result register and the input register; input ready drops
// during the flush and when both are full and the result is not taken.
// Reset is synchronous and clears counters, window and registers; row stores are not cleared.
module median_filter_3x3_top
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pixel_valid,
    output logic                  o_pixel_ready,
    input  logic [PIXEL_BITS-1:0] i_pixel_value,
    output logic                  o_median_valid,
    input  logic                  i_median_ready,
    output logic [PIXEL_BITS-1:0] o_median_value,
    output logic                  o_frame_end,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [FW_BITS-1:0]    r_frame_width;
    logic [FH_BITS-1:0]    r_frame_height;
    logic [FW_BITS-1:0]    eff_w;
    logic [FH_BITS-1:0]    eff_h;
    logic [FW_BITS-1:0]    last_col;
    logic [FH_BITS-1:0]    last_row;

    logic [CW-1:0]         r_col;
    logic [RC_BITS-1:0]    r_row;
    logic                  r_flush;
    logic [FW_BITS-1:0]    r_fcnt;

    logic [PIXEL_BITS-1:0] r_upper [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_lower [MAX_WIDTH];

    logic                  r_s1_valid;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic [CW-1:0]         r_s1_col;
    t_ctl                  r_s1_ctl;
    logic [PIXEL_BITS-1:0] r_top_raw;
    logic [PIXEL_BITS-1:0] r_mid_raw;

    logic [PIXEL_BITS-1:0] r_win [3][3];

    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_out_median;
    logic                  r_out_end;

    logic                  cfg_wr;
    logic [IDX_BITS-1:0]   cfg_idx;
    logic                  s1_adv;
    logic                  s1_free;
    logic                  pix_acc;
    logic                  flush_load;
    logic                  load_s1;
    logic                  at_col_end;
    logic                  at_row_end;
    logic                  fc_end;
    logic [CW-1:0]         fcol;
    logic [CW-1:0]         n_col;
    logic [PIXEL_BITS-1:0] n_pix;
    t_ctl                  n_ctl;
    logic [PIXEL_BITS-1:0] new_col [3];
    logic [PIXEL_BITS-1:0] taps [N_TAPS];
    logic [PIXEL_BITS-1:0] median;

    // effective frame size
    always_comb begin
        if (r_frame_width < FW_BITS'(MIN_DIM)) begin
            eff_w = FW_BITS'(MIN_DIM);
        end else if (r_frame_width > FW_BITS'(MAX_WIDTH)) begin
            eff_w = FW_BITS'(MAX_WIDTH);
        end else begin
            eff_w = r_frame_width;
        end
        if (r_frame_height < FH_BITS'(MIN_DIM)) begin
            eff_h = FH_BITS'(MIN_DIM);
        end else if (r_frame_height > FH_BITS'(MAX_HEIGHT)) begin
            eff_h = FH_BITS'(MAX_HEIGHT);
        end else begin
            eff_h = r_frame_height;
        end
    end

    assign last_col = eff_w - FW_BITS'(1);
    assign last_row = eff_h - FH_BITS'(1);

    // handshake
    assign s1_adv        = r_s1_valid && (!r_out_valid || i_median_ready);
    assign s1_free       = !r_s1_valid || s1_adv;
    assign o_pixel_ready = s1_free && !r_flush;
    assign pix_acc       = i_pixel_valid && o_pixel_ready;
    assign flush_load    = r_flush && s1_free;
    assign load_s1       = pix_acc || flush_load;

    assign at_col_end = FW_BITS'(r_col) == last_col;
    assign at_row_end = FH_BITS'(r_row) == last_row;
    assign fc_end     = r_fcnt == eff_w;
    assign fcol       = fc_end ? '0 : r_fcnt[CW-1:0];

    // entry of the next transaction into the input register
    always_comb begin
        if (r_flush) begin
            n_col            = fcol;
            n_pix            = '0;
            n_ctl.emit       = 1'b1;
            n_ctl.top_ok     = 1'b1;
            n_ctl.mid_ok     = 1'b1;
            n_ctl.zero_left  = fcol == CW'(1);
            n_ctl.zero_right = fcol == '0;
            n_ctl.wr_upper   = 1'b0;
            n_ctl.last       = fc_end;
        end else begin
            n_col            = r_col;
            n_pix            = i_pixel_value;
            n_ctl.emit       = (r_col == '0) ? (r_row >= RC_BITS'(2)) : (r_row != '0);
            n_ctl.top_ok     = r_row >= RC_BITS'(2);
            n_ctl.mid_ok     = r_row != '0;
            n_ctl.zero_left  = r_col == CW'(1);
            n_ctl.zero_right = r_col == '0;
            n_ctl.wr_upper   = 1'b1;
            n_ctl.last       = 1'b0;
        end
    end

    // row stores
    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_top_raw <= r_upper[n_col];
            r_mid_raw <= r_lower[n_col];
        end
        if (pix_acc) begin
            r_lower[r_col] <= i_pixel_value;
        end
        if (s1_adv && r_s1_ctl.wr_upper) begin
            r_upper[r_s1_col] <= r_mid_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_s1_pix <= n_pix;
            r_s1_col <= n_col;
            r_s1_ctl <= n_ctl;
        end
        if (s1_adv && r_s1_ctl.emit) begin
            r_out_median <= median;
            r_out_end    <= r_s1_ctl.last;
        end
    end

    // window column and median taps
    always_comb begin
        new_col[0] = r_s1_ctl.top_ok ? r_top_raw : '0;
        new_col[1] = r_s1_ctl.mid_ok ? r_mid_raw : '0;
        new_col[2] = r_s1_pix;
        for (int k = 0; k < 3; k++) begin
            taps[k]     = r_s1_ctl.zero_left  ? '0 : r_win[1][k];
            taps[3 + k] = r_win[2][k];
            taps[6 + k] = r_s1_ctl.zero_right ? '0 : new_col[k];
        end
    end

    mf3_median #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_median (
        .i_taps   (taps),
        .o_median (median)
    );

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_BITS-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_BITS'(FRAME_WIDTH_RST);
            r_frame_height <= FH_BITS'(FRAME_HEIGHT_RST);
            r_col          <= '0;
            r_row          <= '0;
            r_flush        <= 1'b0;
            r_fcnt         <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[c][k] <= '0;
                end
            end
        end else begin
            if (pix_acc) begin
                if (at_col_end) begin
                    r_col <= '0;
                    if (at_row_end) begin
                        r_row   <= '0;
                        r_flush <= 1'b1;
                        r_fcnt  <= '0;
                    end else begin
                        r_row <= r_row + RC_BITS'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (flush_load) begin
                if (fc_end) begin
                    r_flush <= 1'b0;
                end else begin
                    r_fcnt <= r_fcnt + FW_BITS'(1);
                end
            end

            if (load_s1) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                if (r_s1_ctl.last) begin
                    for (int c = 0; c < 3; c++) begin
                        for (int k = 0; k < 3; k++) begin
                            r_win[c][k] <= '0;
                        end
                    end
                end else begin
                    r_win[0] <= r_win[1];
                    r_win[1] <= r_win[2];
                    r_win[2] <= new_col;
                end
            end

            if (s1_adv && r_s1_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_median_ready) begin
                r_out_valid <= 1'b0;
            end

            // restart the frame on a register write
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_FRAME_WIDTH: begin
                        r_frame_width <= pwdata[FW_BITS-1:0];
                    end
                    REG_FRAME_HEIGHT: begin
                        r_frame_height <= pwdata[FH_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
                r_col   <= '0;
                r_row   <= '0;
                r_flush <= 1'b0;
                for (int c = 0; c < 3; c++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_win[c][k] <= '0;
                    end
                end
            end
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = DATA_BITS'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = DATA_BITS'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign o_median_valid = r_out_valid;
    assign o_median_value = r_out_median;
    assign o_frame_end    = r_out_end;

endmodule

FILE: src/mf3_median.sv
// Nine-input median sorting network, purely combinational.
// Depends on mf3_pkg for the tap count and median rank.
module mf3_median
    import mf3_pkg::*;
#(
    parameter int PIXEL_BITS = 8
) (
    input  logic [PIXEL_BITS-1:0] i_taps [N_TAPS],
    output logic [PIXEL_BITS-1:0] o_median
);

    always_comb begin : sort_net
        logic [PIXEL_BITS-1:0] v [N_TAPS];
        logic [PIXEL_BITS-1:0] t;
        v = i_taps;
        t = '0;
        if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
        if (v[4] > v[5]) begin t = v[4]; v[4] = v[5]; v[5] = t; end
        if (v[7] > v[8]) begin t = v[7]; v[7] = v[8]; v[8] = t; end
        if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
        if (v[3] > v[4]) begin t = v[3]; v[3] = v[4]; v[4] = t; end
        if (v[6] > v[7]) begin t = v[6]; v[6] = v[7]; v[7] = t; end
        if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
        if (v[4] > v[5]) begin t = v[4]; v[4] = v[5]; v[5] = t; end
        if (v[7] > v[8]) begin t = v[7]; v[7] = v[8]; v[8] = t; end
        if (v[0] > v[3]) begin t = v[0]; v[0] = v[3]; v[3] = t; end
        if (v[5] > v[8]) begin t = v[5]; v[5] = v[8]; v[8] = t; end
        if (v[4] > v[7]) begin t = v[4]; v[4] = v[7]; v[7] = t; end
        if (v[3] > v[6]) begin t = v[3]; v[3] = v[6]; v[6] = t; end
        if (v[1] > v[4]) begin t = v[1]; v[1] = v[4]; v[4] = t; end
        if (v[2] > v[5]) begin t = v[2]; v[2] = v[5]; v[5] = t; end
        if (v[4] > v[7]) begin t = v[4]; v[4] = v[7]; v[7] = t; end
        if (v[4] > v[2]) begin t = v[4]; v[4] = v[2]; v[2] = t; end
        if (v[6] > v[4]) begin t = v[6]; v[6] = v[4]; v[4] = t; end
        if (v[4] > v[2]) begin t = v[4]; v[4] = v[2]; v[2] = t; end
        o_median = v[MEDIAN_RANK];
    end

endmodule

FILE: src/mf3_checker.sv
// Port-level checks of the 3x3 median filter over time.
// Bound to median_filter_3x3_top; sees only its ports.
module mf3_checker #(
    parameter int PIXEL_BITS = 8
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_median_valid,
    input logic                  i_median_ready,
    input logic [PIXEL_BITS-1:0] o_median_value,
    input logic                  o_frame_end,
    input logic                  pready
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_median_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_median_valid && !i_median_ready |=>
            o_median_valid && $stable(o_median_value) && $stable(o_frame_end))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

    a_frame_end_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_median_valid && i_median_ready && o_frame_end |=>
            !(o_median_valid && o_frame_end))
        else $error("two frame ends in a row");

endmodule

bind median_filter_3x3_top mf3_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_mf3_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_median_valid (o_median_valid),
    .i_median_ready (i_median_ready),
    .o_median_value (o_median_value),
    .o_frame_end    (o_frame_end),
    .pready         (pready)
);
